### hw/rtl/chpp_pkg.sv
// shared types and constants of the colon header packet parser
package chpp_pkg;

    localparam logic [7:0] COLON      = 8'h3a;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int unsigned ACC_W    = 16;
    localparam int unsigned PROD_W   = 20;
    localparam logic [ACC_W-1:0] TYPE_LIMIT = 16'hffff;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_SRC     = 2'd1,
        KIND_SRC_END = 2'd2,
        KIND_PAYLOAD = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_BLANK  = 2'd0,
        ST_SIGN   = 2'd1,
        ST_DIGITS = 2'd2,
        ST_DONE   = 2'd3
    } stage_t;

    typedef struct packed {
        stage_t stage;
        logic   neg;
        logic   err;
    } num_flags_t;

endpackage

### hw/rtl/chpp_number.sv
// one byte step of the decimal number field reader
module chpp_number
(
    input  logic [7:0]                   rx_byte,
    input  logic [chpp_pkg::ACC_W-1:0]   acc,
    input  logic [chpp_pkg::ACC_W-1:0]   limit,
    input  logic                         is_size,
    input  chpp_pkg::stage_t             stage,
    output logic [chpp_pkg::ACC_W-1:0]   acc_next,
    output chpp_pkg::num_flags_t         flags
);

    logic                          digit;
    logic                          blank;
    logic                          sign;
    logic [chpp_pkg::PROD_W-1:0]   acc_wide;
    logic [chpp_pkg::PROD_W-1:0]   prod;

    assign digit = (rx_byte >= chpp_pkg::CHAR_ZERO) && (rx_byte <= chpp_pkg::CHAR_NINE);
    assign blank = (rx_byte == chpp_pkg::CHAR_SPACE) ||
                   ((rx_byte >= chpp_pkg::CHAR_TAB) && (rx_byte <= chpp_pkg::CHAR_CR));
    assign sign  = (rx_byte == chpp_pkg::CHAR_PLUS) || (rx_byte == chpp_pkg::CHAR_MINUS);

    // acc * 10 + digit as two shifts and adds
    assign acc_wide = {{(chpp_pkg::PROD_W - chpp_pkg::ACC_W){1'b0}}, acc};
    assign prod     = (acc_wide << 3) + (acc_wide << 1) +
                      {{(chpp_pkg::PROD_W - 4){1'b0}}, rx_byte[3:0]};

    always_comb
    begin
        acc_next    = acc;
        flags.stage = stage;
        flags.neg   = 1'b0;
        flags.err   = 1'b0;
        priority if (stage == chpp_pkg::ST_DONE)
        begin
            acc_next = acc;
        end
        else if ((stage == chpp_pkg::ST_BLANK) && blank)
        begin
            acc_next = acc;
        end
        else if ((stage == chpp_pkg::ST_BLANK) && sign)
        begin
            flags.stage = chpp_pkg::ST_SIGN;
            flags.neg   = (rx_byte == chpp_pkg::CHAR_MINUS);
            flags.err   = (rx_byte == chpp_pkg::CHAR_MINUS);
        end
        else if (!digit)
        begin
            flags.stage = chpp_pkg::ST_DONE;
        end
        else
        begin
            flags.stage = chpp_pkg::ST_DIGITS;
            if (prod > {{(chpp_pkg::PROD_W - chpp_pkg::ACC_W){1'b0}}, limit})
            begin
                acc_next  = limit;
                flags.err = is_size;
            end
            else
            begin
                acc_next = prod[chpp_pkg::ACC_W-1:0];
            end
        end
    end

endmodule

### hw/rtl/chpp_parse_core.sv
// frame state machine: parser state and the result of the item in the input register
module chpp_parse_core
#(
    parameter int unsigned DATA_MAX = 1024,
    parameter int unsigned SIZE_W   = $clog2(DATA_MAX + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output chpp_pkg::kind_t     res_kind,
    output logic [15:0]         res_type,
    output logic [SIZE_W-1:0]   res_size,
    output logic                res_error,
    output logic [7:0]          res_byte,
    output logic                res_last
);

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_SIZE = 2'd1,
        PH_SRC  = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    phase_t                        phase_reg,  phase_next;
    logic [15:0]                   type_reg,   type_next;
    logic [SIZE_W-1:0]             size_reg,   size_next;
    chpp_pkg::stage_t              stage_reg,  stage_next;
    logic                          neg_reg,    neg_next;
    logic                          err_reg,    err_next;
    logic [SIZE_W-1:0]             left_reg,   left_next;

    logic [chpp_pkg::ACC_W-1:0]    num_acc;
    logic [chpp_pkg::ACC_W-1:0]    num_limit;
    logic [chpp_pkg::ACC_W-1:0]    num_acc_next;
    chpp_pkg::num_flags_t          num_flags;
    logic                          is_colon;
    logic [SIZE_W-1:0]             size_eff;
    logic [SIZE_W-1:0]             left_dec;

    assign is_colon  = (rx_byte == chpp_pkg::COLON);
    assign num_acc   = (phase_reg == PH_SIZE) ?
                       chpp_pkg::ACC_W'(size_reg) : type_reg;
    assign num_limit = (phase_reg == PH_SIZE) ?
                       chpp_pkg::ACC_W'(DATA_MAX) : chpp_pkg::TYPE_LIMIT;
    assign size_eff  = neg_reg ? '0 : size_reg;
    assign left_dec  = left_reg - SIZE_W'(left_reg != '0);

    chpp_number u_number
    (
        .rx_byte  (rx_byte),
        .acc      (num_acc),
        .limit    (num_limit),
        .is_size  (phase_reg == PH_SIZE),
        .stage    (stage_reg),
        .acc_next (num_acc_next),
        .flags    (num_flags)
    );

    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        size_next  = size_reg;
        stage_next = stage_reg;
        neg_next   = neg_reg;
        err_next   = err_reg;
        left_next  = left_reg;
        res_valid  = 1'b0;
        res_kind   = chpp_pkg::KIND_HEADER;
        res_type   = '0;
        res_size   = '0;
        res_error  = 1'b0;
        res_byte   = '0;
        res_last   = 1'b0;
        unique case (phase_reg)
            PH_TYPE:
            begin
                if (is_colon)
                begin
                    if (neg_reg)
                        type_next = '0;
                    neg_next   = 1'b0;
                    stage_next = chpp_pkg::ST_BLANK;
                    phase_next = PH_SIZE;
                end
                else
                begin
                    type_next  = num_acc_next;
                    stage_next = num_flags.stage;
                    neg_next   = neg_reg | num_flags.neg;
                    err_next   = err_reg | num_flags.err;
                end
            end
            PH_SIZE:
            begin
                if (is_colon)
                begin
                    size_next  = size_eff;
                    left_next  = size_eff;
                    phase_next = PH_SRC;
                    res_valid  = 1'b1;
                    res_kind   = chpp_pkg::KIND_HEADER;
                    res_type   = type_reg;
                    res_size   = size_eff;
                    res_error  = err_reg;
                end
                else
                begin
                    size_next  = num_acc_next[SIZE_W-1:0];
                    stage_next = num_flags.stage;
                    neg_next   = neg_reg | num_flags.neg;
                    err_next   = err_reg | num_flags.err;
                end
            end
            PH_SRC:
            begin
                res_valid = 1'b1;
                if (is_colon)
                begin
                    res_kind = chpp_pkg::KIND_SRC_END;
                    if (left_reg == '0)
                        res_last = 1'b1;
                    else
                        phase_next = PH_DATA;
                end
                else
                begin
                    res_kind = chpp_pkg::KIND_SRC;
                    res_byte = rx_byte;
                end
            end
            PH_DATA:
            begin
                res_valid = 1'b1;
                res_kind  = chpp_pkg::KIND_PAYLOAD;
                res_byte  = rx_byte;
                left_next = left_dec;
                res_last  = (left_dec == '0);
            end
            default:
            begin
                phase_next = PH_TYPE;
            end
        endcase
        // end of frame: rearm for the next one
        if (res_last)
        begin
            phase_next = PH_TYPE;
            type_next  = '0;
            size_next  = '0;
            stage_next = chpp_pkg::ST_BLANK;
            neg_next   = 1'b0;
            err_next   = 1'b0;
            left_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            type_reg  <= '0;
            size_reg  <= '0;
            stage_reg <= chpp_pkg::ST_BLANK;
            neg_reg   <= 1'b0;
            err_reg   <= 1'b0;
            left_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            size_reg  <= size_next;
            stage_reg <= stage_next;
            neg_reg   <= neg_next;
            err_reg   <= err_next;
            left_reg  <= left_next;
        end
    end

endmodule

### hw/rtl/colon_header_packet_parser.sv
// top level of the colon header packet parser: input register, parser, result register
//
// channel | dir | tdata (low bit up)                             | tuser | tlast
// s_axis  | in  | rx_byte                                        | -     | -
// m_axis  | out | msg_type, msg_size, header_error, out_byte, pad | kind  | last
//
// one input byte per cycle sustained while m_axis_tready stays high
// each byte passes the input register, then the parser, then the result register
// rst_n clears the parser state and both valid flags; payload registers keep no reset
// a stalled result holds; the next item still enters the input register if that is empty
module colon_header_packet_parser
#(
    parameter int unsigned DATA_MAX = 1024,
    parameter int unsigned SIZE_W   = $clog2(DATA_MAX + 1),
    parameter int unsigned TDATA_W  = ((25 + SIZE_W + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // rx_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // msg_type, msg_size, header_error, out_byte
    output logic [1:0]         m_axis_tuser,   // kind
    output logic               m_axis_tlast    // last
);

    localparam int unsigned USED_W = 25 + SIZE_W;

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    chpp_pkg::kind_t      out_kind_reg;
    logic [15:0]          out_type_reg;
    logic [SIZE_W-1:0]    out_size_reg;
    logic                 out_err_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;

    logic                 out_free;
    logic                 advance;
    logic                 res_valid;
    chpp_pkg::kind_t      res_kind;
    logic [15:0]          res_type;
    logic [SIZE_W-1:0]    res_size;
    logic                 res_error;
    logic [7:0]           res_byte;
    logic                 res_last;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
    end

    chpp_parse_core #(
        .DATA_MAX (DATA_MAX),
        .SIZE_W   (SIZE_W)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res_kind  (res_kind),
        .res_type  (res_type),
        .res_size  (res_size),
        .res_error (res_error),
        .res_byte  (res_byte),
        .res_last  (res_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_kind_reg <= res_kind;
            out_type_reg <= res_type;
            out_size_reg <= res_size;
            out_err_reg  <= res_error;
            out_byte_reg <= res_byte;
            out_last_reg <= res_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(TDATA_W - USED_W){1'b0}},
                            out_byte_reg, out_err_reg, out_size_reg, out_type_reg};

endmodule

### hw/rtl/chpp_checker.sv
// port-level checks of the colon header packet parser and their bind
module chpp_checker
#(
    parameter int unsigned DATA_MAX = 1024,
    parameter int unsigned SIZE_W   = $clog2(DATA_MAX + 1),
    parameter int unsigned TDATA_W  = ((25 + SIZE_W + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [TDATA_W-1:0] m_axis_tdata,
    input  logic [1:0]         m_axis_tuser,
    input  logic               m_axis_tlast
);

    localparam int unsigned HDR_W = 17 + SIZE_W;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("result item changed while stalled");

    // a header never closes a frame
    a_header_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == chpp_pkg::KIND_HEADER) |-> !m_axis_tlast)
        else $error("header item marked last");

    // header fields are zero on byte and marker items
    a_header_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != chpp_pkg::KIND_HEADER) |->
            (m_axis_tdata[HDR_W-1:0] == '0))
        else $error("header fields set outside a header item");

    // header size never above the limit
    a_size_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == chpp_pkg::KIND_HEADER) |->
            ({{(32 - SIZE_W){1'b0}}, m_axis_tdata[16 +: SIZE_W]} <= DATA_MAX))
        else $error("header size above limit");

    // the input side is free once out of reset
    a_ready_after_reset: assert property (@(posedge clk)
        $past(!rst_n) && rst_n |-> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind colon_header_packet_parser chpp_checker #(
    .DATA_MAX (DATA_MAX),
    .SIZE_W   (SIZE_W),
    .TDATA_W  (TDATA_W)
) u_chpp_checker (.*);

### bench/colon_header_packet_parser_tb.sv
// self-checking testbench of the colon header packet parser
`timescale 1ns / 100ps

module colon_header_packet_parser_tb;

    localparam int unsigned DATA_MAX      = 1024;
    localparam int unsigned SIZE_W        = 11;
    localparam int unsigned TDATA_W       = 40;
    localparam int unsigned ERR_BIT       = 16 + SIZE_W;
    localparam int unsigned BYTE_LO       = ERR_BIT + 1;
    localparam int unsigned RANDOM_ITEMS  = 1100;
    localparam int unsigned OVERSIZE_TAIL = 48;
    localparam int unsigned HOLD_START    = 600;
    localparam int unsigned HOLD_LEN      = 400;
    localparam int unsigned DRAIN_CYCLES  = 16;
    localparam int unsigned TIMEOUT_NS    = 2_000_000;
    localparam int unsigned REPORT_LIMIT  = 10;

    localparam logic [7:0] CHAR_LF = 8'h0a;
    localparam logic [7:0] CHAR_VT = 8'h0b;
    localparam logic [7:0] CHAR_FF = 8'h0c;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_SIZE = 2'd1,
        PH_SRC  = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        RX_OPEN     = 2'd0,
        RX_COIN     = 2'd1,
        RX_PERIODIC = 2'd2,
        RX_SPARSE   = 2'd3
    } rx_mode_t;

    typedef struct {
        chpp_pkg::kind_t kind;
        logic [15:0]     msg_type;
        logic [10:0]     msg_size;
        logic            header_error;
        logic [7:0]      out_byte;
        logic            last;
    } parse_result_t;

    class parser_scoreboard;
        phase_t           phase;
        chpp_pkg::stage_t stage;
        int unsigned      type_acc;
        int unsigned      size_acc;
        int unsigned      bytes_left;
        bit               neg_seen;
        bit               err_seen;
        parse_result_t    pending_results[$];
        int unsigned      failures;
        int unsigned      checked;
        int unsigned      frames_closed;
        int unsigned      flagged_headers;

        function new();
            rearm();
            failures        = 0;
            checked         = 0;
            frames_closed   = 0;
            flagged_headers = 0;
        endfunction

        function void rearm();
            phase      = PH_TYPE;
            stage      = chpp_pkg::ST_BLANK;
            type_acc   = 0;
            size_acc   = 0;
            bytes_left = 0;
            neg_seen   = 1'b0;
            err_seen   = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == chpp_pkg::CHAR_SPACE ||
                   (b >= chpp_pkg::CHAR_TAB && b <= chpp_pkg::CHAR_CR);
        endfunction

        // atoi-like accumulation of one non-colon byte
        function int unsigned feed_number(logic [7:0] b, int unsigned acc,
                                          int unsigned limit, bit is_size);
            bit digit;
            digit = (b >= chpp_pkg::CHAR_ZERO && b <= chpp_pkg::CHAR_NINE);
            if (stage == chpp_pkg::ST_DONE)
                return acc;
            if (stage == chpp_pkg::ST_BLANK)
            begin
                if (is_blank(b))
                    return acc;
                if (b == chpp_pkg::CHAR_PLUS || b == chpp_pkg::CHAR_MINUS)
                begin
                    if (b == chpp_pkg::CHAR_MINUS)
                    begin
                        neg_seen = 1'b1;
                        err_seen = 1'b1;
                    end
                    stage = chpp_pkg::ST_SIGN;
                    return acc;
                end
            end
            if (!digit)
            begin
                stage = chpp_pkg::ST_DONE;
                return acc;
            end
            stage = chpp_pkg::ST_DIGITS;
            acc = acc * 10 + (b - chpp_pkg::CHAR_ZERO);
            if (acc > limit)
            begin
                acc = limit;
                if (is_size)
                    err_seen = 1'b1;
            end
            return acc;
        endfunction

        function void add_expected(chpp_pkg::kind_t k, logic [15:0] t, logic [10:0] s,
                                   logic e, logic [7:0] ob, logic l);
            parse_result_t r;
            r.kind         = k;
            r.msg_type     = t;
            r.msg_size     = s;
            r.header_error = e;
            r.out_byte     = ob;
            r.last         = l;
            pending_results.push_back(r);
        endfunction

        function void note_rx_byte(logic [7:0] b);
            case (phase)
                PH_TYPE:
                begin
                    if (b == chpp_pkg::COLON)
                    begin
                        if (neg_seen)
                            type_acc = 0;
                        neg_seen = 1'b0;
                        stage    = chpp_pkg::ST_BLANK;
                        phase    = PH_SIZE;
                    end
                    else
                        type_acc = feed_number(b, type_acc, 65535, 1'b0);
                end
                PH_SIZE:
                begin
                    if (b == chpp_pkg::COLON)
                    begin
                        if (neg_seen)
                            size_acc = 0;
                        bytes_left = size_acc;
                        phase      = PH_SRC;
                        add_expected(chpp_pkg::KIND_HEADER, type_acc[15:0], size_acc[10:0],
                                     err_seen, 8'h00, 1'b0);
                    end
                    else
                        size_acc = feed_number(b, size_acc, DATA_MAX, 1'b1);
                end
                PH_SRC:
                begin
                    if (b != chpp_pkg::COLON)
                        add_expected(chpp_pkg::KIND_SRC, 16'h0, 11'h0, 1'b0, b, 1'b0);
                    else if (bytes_left == 0)
                    begin
                        // empty size closes the frame on the source-end marker
                        add_expected(chpp_pkg::KIND_SRC_END, 16'h0, 11'h0, 1'b0,
                                     8'h00, 1'b1);
                        rearm();
                    end
                    else
                    begin
                        add_expected(chpp_pkg::KIND_SRC_END, 16'h0, 11'h0, 1'b0,
                                     8'h00, 1'b0);
                        phase = PH_DATA;
                    end
                end
                default:
                begin
                    if (bytes_left > 0)
                        bytes_left--;
                    if (bytes_left == 0)
                    begin
                        add_expected(chpp_pkg::KIND_PAYLOAD, 16'h0, 11'h0, 1'b0, b, 1'b1);
                        rearm();
                    end
                    else
                        add_expected(chpp_pkg::KIND_PAYLOAD, 16'h0, 11'h0, 1'b0, b, 1'b0);
                end
            endcase
        endfunction

        function void check_result(logic [TDATA_W-1:0] data, logic [1:0] user,
                                   logic last);
            parse_result_t got;
            parse_result_t want;
            bit            bad;
            got.kind         = chpp_pkg::kind_t'(user);
            got.msg_type     = data[15:0];
            got.msg_size     = data[ERR_BIT-1:16];
            got.header_error = data[ERR_BIT];
            got.out_byte     = data[BYTE_LO+7:BYTE_LO];
            got.last         = last;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("%0t: result with nothing pending", $time);
                    $display("  actual   kind %0d type %0d size %0d err %0b byte %02h last %0b",
                             got.kind, got.msg_type, got.msg_size,
                             got.header_error, got.out_byte, got.last);
                end
                return;
            end
            want = pending_results.pop_front();
            checked++;
            bad = (got.kind !== want.kind) || (got.msg_type !== want.msg_type) ||
                  (got.msg_size !== want.msg_size) ||
                  (got.header_error !== want.header_error) ||
                  (got.out_byte !== want.out_byte) || (got.last !== want.last);
            if (bad)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("%0t: mismatch on result %0d", $time, checked);
                    $display("  expected kind %0d type %0d size %0d err %0b byte %02h last %0b",
                             want.kind, want.msg_type, want.msg_size,
                             want.header_error, want.out_byte, want.last);
                    $display("  actual   kind %0d type %0d size %0d err %0b byte %02h last %0b",
                             got.kind, got.msg_type, got.msg_size,
                             got.header_error, got.out_byte, got.last);
                end
            end
            else
            begin
                if (want.last)
                    frames_closed++;
                if (want.kind == chpp_pkg::KIND_HEADER && want.header_error)
                    flagged_headers++;
            end
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [1:0]         m_axis_tuser;
    logic               m_axis_tlast;

    parser_scoreboard sb = new();
    logic [7:0]       stream_q[$];
    int unsigned      items_sent = 0;

    colon_header_packet_parser #(
        .DATA_MAX (DATA_MAX)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] rand_non_colon();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == chpp_pkg::COLON);
        return b;
    endfunction

    // any byte that neither ends the field nor counts as a digit
    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == chpp_pkg::COLON ||
               (b >= chpp_pkg::CHAR_ZERO && b <= chpp_pkg::CHAR_NINE));
        return b;
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 5))
            0:       return chpp_pkg::CHAR_SPACE;
            1:       return chpp_pkg::CHAR_TAB;
            2:       return CHAR_LF;
            3:       return CHAR_VT;
            4:       return CHAR_FF;
            default: return chpp_pkg::CHAR_CR;
        endcase
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            stream_q.push_back(s[i]);
    endtask

    // writes one decimal field and returns the value the parser will settle on for a size field
    task automatic push_number(input int unsigned value, input bit size_field,
                               input bit plain, output int unsigned effective);
        logic [7:0]  digs[$];
        int unsigned v;
        int unsigned pick;
        bit          minus;
        bit          no_digits;
        v         = value;
        minus     = 1'b0;
        no_digits = 1'b0;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) stream_q.push_back(rand_blank());
        pick = plain ? 15 : $urandom_range(0, 15);
        if (pick == 0)
        begin
            minus = 1'b1;
            stream_q.push_back(chpp_pkg::CHAR_MINUS);
        end
        else if (pick < 3)
            stream_q.push_back(chpp_pkg::CHAR_PLUS);
        if (!plain && $urandom_range(0, 11) == 0)
        begin
            no_digits = 1'b1;
            if ($urandom_range(0, 1) == 1)
                stream_q.push_back(rand_text_byte());
        end
        else
        begin
            if ($urandom_range(0, 5) == 0)
                stream_q.push_back(chpp_pkg::CHAR_ZERO);
            do
            begin
                digs.push_front(8'(chpp_pkg::CHAR_ZERO + v % 10));
                v = v / 10;
            end
            while (v != 0);
            foreach (digs[i])
                stream_q.push_back(digs[i]);
            // trailing junk is skipped up to the colon
            if ($urandom_range(0, 5) == 0)
            begin
                stream_q.push_back(rand_text_byte());
                if ($urandom_range(0, 1) == 1)
                    stream_q.push_back(8'(chpp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            end
        end
        if (minus || no_digits)
            effective = 0;
        else if (size_field && value > DATA_MAX)
            effective = DATA_MAX;
        else
            effective = value;
    endtask

    task automatic add_frame(input bit oversized);
        int unsigned tval;
        int unsigned sval;
        int unsigned plen;
        int unsigned nsrc;
        int unsigned unused;
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 6)) stream_q.push_back(rand_non_colon());
        case ($urandom_range(0, 19))
            0:       tval = $urandom_range(65536, 999999);
            1, 2:    tval = $urandom_range(1000, 65535);
            default: tval = $urandom_range(0, 999);
        endcase
        push_number(tval, 1'b0, 1'b0, unused);
        stream_q.push_back(chpp_pkg::COLON);
        if (oversized)
            sval = $urandom_range(DATA_MAX + 1, 5000);
        else if ($urandom_range(0, 7) == 0)
            sval = 0;
        else
            sval = $urandom_range(1, 24);
        push_number(sval, 1'b1, oversized, plen);
        stream_q.push_back(chpp_pkg::COLON);
        nsrc = ($urandom_range(0, 29) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
        repeat (nsrc) stream_q.push_back(rand_non_colon());
        stream_q.push_back(chpp_pkg::COLON);
        // the oversized frame ends the stream, so only the head of its payload goes out
        if (oversized)
            plen = OVERSIZE_TAIL;
        repeat (plen) stream_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_stream();
        int unsigned burst;
        int unsigned gap;
        logic [7:0]  cur;
        burst = 0;
        while (stream_q.size() != 0)
        begin
            if (burst == 0)
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
            end
            cur = stream_q.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= cur;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            sb.note_rx_byte(cur);
            items_sent++;
            burst--;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // receiver: changing stall patterns plus one long hold-off
    initial
    begin
        int unsigned cycles;
        int unsigned mode_left;
        rx_mode_t    mode;
        cycles    = 0;
        mode_left = 0;
        mode      = RX_OPEN;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= HOLD_START && cycles < HOLD_START + HOLD_LEN)
                m_axis_tready <= 1'b0;
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 128);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:     m_axis_tready <= 1'b1;
                    RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_axis_tready <= (cycles % 4) != 0;
                    default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results still pending", sb.pending());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a blank and plus on the type, minus with no digits, empty size
        push_text(" +7:-:x:");
        // saturating type, zero byte in the source name
        push_text("99999:2:");
        stream_q.push_back(8'h00);
        stream_q.push_back(chpp_pkg::COLON);
        stream_q.push_back(8'hff);
        stream_q.push_back(8'h00);
        // negative type, zero byte ending the size, empty source, colon as payload
        push_text("\t-3:");
        stream_q.push_back(chpp_pkg::CHAR_CR);
        push_text("1");
        stream_q.push_back(8'h00);
        push_text("::");
        stream_q.push_back(chpp_pkg::COLON);

        while (stream_q.size() < RANDOM_ITEMS - OVERSIZE_TAIL - 16)
            add_frame(1'b0);
        add_frame(1'b1);

        send_stream();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.failures++;

        $display("sent %0d bytes, checked %0d results over %0d closed frames",
                 items_sent, sb.checked, sb.frames_closed);
        $display("%0d headers carried the error flag, %0d failures",
                 sb.flagged_headers, sb.failures);
        if (sb.failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
